>>> sv/rnorm_pkg.sv
// Shared constants for the rational normalizer.
package rnorm_pkg;

   localparam int WORD_BITS = 32;
   localparam int DEN_BITS  = WORD_BITS - 1;
   localparam int CNT_BITS  = $clog2(WORD_BITS);

   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(WORD_BITS - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_GCD   = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

endpackage

>>> sv/rational_normalizer.sv
// Rational normalizer top level: fraction reduction by binary GCD and serial division.
//
// Input channel req_: req_num_in / req_den_in, signed two's complement fraction.
// Result channel rsp_: rsp_num_out (signed, carries the sign) and rsp_den_out
// (unsigned, non-negative) hold the fraction in lowest terms. A zero numerator
// gives 0/1; a zero denominator with a nonzero numerator gives +1/0 or -1/0.
// One item is processed at a time. After a transfer on req_ the block runs:
//   binary GCD on the magnitudes, one shift or subtract-and-shift per cycle;
//   the common power of two restored one bit per cycle;
//   both divisions by the GCD as restoring dividers side by side, one quotient
//   bit per cycle;
//   then the output register is loaded once it is free.
// A zero numerator skips straight to the output register.
// req_ready is high whenever the sequencer is idle, also while a result still
// waits in the output register. When the receiver stalls, a finished result
// waits in the sequencer until the output register frees up.
// Reset is synchronous and clears the sequencer and the output valid.
module rational_normalizer
   import rnorm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [WORD_BITS-1:0] req_num_in,
   input  logic signed [WORD_BITS-1:0] req_den_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_num_out,
   output logic        [DEN_BITS-1:0]  rsp_den_out
);

   logic [2:0]           state_ff, state_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [WORD_BITS-1:0] g_ff, g_in;
   logic [CNT_BITS-1:0]  k_ff, k_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] nq_ff, nq_in;
   logic [WORD_BITS-1:0] dq_ff, dq_in;
   logic [WORD_BITS-1:0] rn_ff, rn_in;
   logic [WORD_BITS-1:0] rd_ff, rd_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_num_ff, rsp_num_in;
   logic [DEN_BITS-1:0]  rsp_den_ff, rsp_den_in;

   logic                 accept;
   logic [WORD_BITS-1:0] num_mag, den_mag;
   logic [WORD_BITS:0]   a_minus_b, b_minus_a;
   logic [WORD_BITS:0]   tn, td, sn, sd;
   logic                 out_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign num_mag = req_num_in[WORD_BITS-1] ? (~req_num_in + 1'b1) : req_num_in;
   assign den_mag = req_den_in[WORD_BITS-1] ? (~req_den_in + 1'b1) : req_den_in;

   assign a_minus_b = {1'b0, a_ff} - {1'b0, b_ff};
   assign b_minus_a = {1'b0, b_ff} - {1'b0, a_ff};

   assign tn = {rn_ff, nq_ff[WORD_BITS-1]};
   assign td = {rd_ff, dq_ff[WORD_BITS-1]};
   assign sn = tn - {1'b0, g_ff};
   assign sd = td - {1'b0, g_ff};

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      g_in         = g_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      nq_in        = nq_ff;
      dq_in        = dq_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_num_in == '0) begin
                  nq_in    = '0;
                  dq_in    = WORD_BITS'(1);
                  neg_in   = 1'b0;
                  state_in = S_OUT;
               end else begin
                  a_in     = num_mag;
                  b_in     = den_mag;
                  nq_in    = num_mag;
                  dq_in    = den_mag;
                  k_in     = '0;
                  neg_in   = req_num_in[WORD_BITS-1] ^ req_den_in[WORD_BITS-1];
                  state_in = S_GCD;
               end
            end
         end
         S_GCD: begin
            if (a_ff == '0) begin
               g_in     = b_ff;
               state_in = S_SHIFT;
            end else if (b_ff == '0) begin
               g_in     = a_ff;
               state_in = S_SHIFT;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (!a_minus_b[WORD_BITS]) begin
               a_in = a_minus_b[WORD_BITS:1];
            end else begin
               b_in = b_minus_a[WORD_BITS:1];
            end
         end
         S_SHIFT: begin
            if (k_ff == '0) begin
               rn_in    = '0;
               rd_in    = '0;
               cnt_in   = LAST_STEP;
               state_in = S_DIV;
            end else begin
               g_in = g_ff << 1;
               k_in = k_ff - 1'b1;
            end
         end
         S_DIV: begin
            if (!sn[WORD_BITS]) begin
               rn_in = sn[WORD_BITS-1:0];
            end else begin
               rn_in = tn[WORD_BITS-1:0];
            end
            if (!sd[WORD_BITS]) begin
               rd_in = sd[WORD_BITS-1:0];
            end else begin
               rd_in = td[WORD_BITS-1:0];
            end
            nq_in = {nq_ff[WORD_BITS-2:0], !sn[WORD_BITS]};
            dq_in = {dq_ff[WORD_BITS-2:0], !sd[WORD_BITS]};
            if (cnt_ff == '0) begin
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = neg_ff ? (~nq_ff + 1'b1) : nq_ff;
               rsp_den_in   = dq_ff[DEN_BITS-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      g_ff       <= g_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      nq_ff      <= nq_in;
      dq_ff      <= dq_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      neg_ff     <= neg_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_num_out = rsp_num_ff;
   assign rsp_den_out = rsp_den_ff;

endmodule

>>> bench/tb.sv
// Testbench for rational_normalizer: random and directed fractions against a predictor.
module tb
   import rnorm_pkg::*;
();

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic        [DEN_BITS-1:0]  den_type;

   localparam int       PERIOD         = 12;
   localparam int       LIMIT_CYCLES   = 3_000_000;
   localparam int       RAND_PER_PHASE = 382;
   localparam word_type MAX_POS        = 32'sh7FFF_FFFF;
   localparam word_type MIN_NEG        = 32'sh8000_0000;

   localparam int SEND_IDLE_PCT [4] = '{0, 48, 0, 34};
   localparam int RECV_STALL_PCT[4] = '{0, 0, 48, 34};

   class frac_scoreboard_type;
      word_type sent_num_q[$];
      word_type sent_den_q[$];
      word_type reduced_num_q[$];
      den_type  reduced_den_q[$];
      int       errors;

      function new();
         errors = 0;
      endfunction

      // lowest terms, denominator non-negative, 0/x -> 0/1, x/0 -> sign(x)/0
      function void reduce_fraction(input word_type n, input word_type d,
                                    output word_type qn, output den_type qd);
         logic [WORD_BITS-1:0] nm, dm, a, b, r, g, un, ud;
         if (n == 0) begin
            qn = '0;
            qd = DEN_BITS'(1);
            return;
         end
         nm = n[WORD_BITS-1] ? -n : n;
         dm = d[WORD_BITS-1] ? -d : d;
         a  = nm;
         b  = dm;
         while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
         end
         g  = (a == 0) ? 1 : a;
         un = nm / g;
         ud = dm / g;
         qn = (n[WORD_BITS-1] ^ d[WORD_BITS-1]) ? word_type'(-un) : word_type'(un);
         qd = ud[DEN_BITS-1:0];
      endfunction

      function void note_input(input word_type n, input word_type d);
         word_type qn;
         den_type  qd;
         reduce_fraction(n, d, qn, qd);
         sent_num_q.push_back(n);
         sent_den_q.push_back(d);
         reduced_num_q.push_back(qn);
         reduced_den_q.push_back(qd);
      endfunction

      function int pending();
         return reduced_num_q.size();
      endfunction

      task report(input string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_result(input word_type num, input den_type den);
         word_type in_n, in_d, en;
         den_type  ed;
         if (reduced_num_q.size() == 0) begin
            report($sformatf("unexpected result %0d/%0d", num, den));
            return;
         end
         in_n = sent_num_q.pop_front();
         in_d = sent_den_q.pop_front();
         en   = reduced_num_q.pop_front();
         ed   = reduced_den_q.pop_front();
         if (num !== en)
            report($sformatf("%0d/%0d: num_out %0d, want %0d", in_n, in_d, num, en));
         if (den !== ed)
            report($sformatf("%0d/%0d: den_out %0d, want %0d", in_n, in_d, den, ed));
      endtask
   endclass

   logic     clock      = 1'b0;
   logic     reset      = 1'b1;
   logic     req_valid  = 1'b0;
   word_type req_num_in = '0;
   word_type req_den_in = '0;
   logic     rsp_ready  = 1'b0;
   logic     req_ready;
   logic     rsp_valid;
   word_type rsp_num_out;
   den_type  rsp_den_out;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   frac_scoreboard_type sb;

   rational_normalizer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_num_in  (req_num_in),
      .req_den_in  (req_den_in),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_num_out (rsp_num_out),
      .rsp_den_out (rsp_den_out)
   );

   initial begin
      forever #(PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(PERIOD * LIMIT_CYCLES);
      $display("Regression FAIL");
      $finish;
   end

   // receiver: random stalls, now and then a long one so results back up
   always begin
      @(posedge clock);
      if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
         rsp_ready <= 1'b0;
         if ($urandom_range(499) == 0)
            repeat ($urandom_range(130, 300)) @(posedge clock);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_num_out, rsp_den_out);
   end

   function word_type rand_word();
      word_type v;
      v = $urandom;
      if (v == MIN_NEG)
         v = MAX_POS;
      return v;
   endfunction

   function word_type signed_as(input word_type v, input bit neg);
      return neg ? -v : v;
   endfunction

   function void gen_fraction(output word_type n, output word_type d);
      int unsigned gb, ab, g, a, b;
      case ($urandom_range(9))
         1: begin
            n = $signed($urandom_range(40)) - 20;
            d = $signed($urandom_range(40)) - 20;
         end
         2, 3, 4: begin
            // shared factor, product stays below 2^31
            gb = $urandom_range(1, 30);
            ab = 31 - gb;
            g  = ($urandom & ((32'd1 << gb) - 1)) | (32'd1 << (gb - 1));
            a  = $urandom & ((32'd1 << ab) - 1);
            b  = $urandom & ((32'd1 << ab) - 1);
            n  = signed_as(word_type'(a * g), 1'($urandom_range(1)));
            d  = signed_as(word_type'(b * g), 1'($urandom_range(1)));
         end
         5: begin
            n = signed_as(word_type'(32'd1 << $urandom_range(30)), 1'($urandom_range(1)));
            d = signed_as(word_type'(32'd1 << $urandom_range(30)), 1'($urandom_range(1)));
         end
         6: begin
            n = '0;
            d = ($urandom_range(3) == 0) ? word_type'(0) : rand_word();
         end
         7: begin
            n = rand_word();
            d = '0;
         end
         8: begin
            d = signed_as(MAX_POS - $urandom_range(3), 1'($urandom_range(1)));
            n = signed_as(($urandom_range(1) != 0) ? d : MAX_POS - $urandom_range(3),
                          1'($urandom_range(1)));
         end
         default: begin
            n = rand_word();
            d = rand_word();
         end
      endcase
   endfunction

   task send_fraction(input word_type n, input word_type d);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(3) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 4))
            @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_num_in <= n;
      req_den_in <= d;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_input(n, d);
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task run_directed();
      send_fraction(0, 5);
      send_fraction(0, 0);
      send_fraction(0, -7);
      send_fraction(0, MAX_POS);
      send_fraction(5, 0);
      send_fraction(-5, 0);
      send_fraction(MAX_POS, 0);
      send_fraction(-MAX_POS, 0);
      send_fraction(MAX_POS, MAX_POS);
      send_fraction(MAX_POS, -MAX_POS);
      send_fraction(-MAX_POS, MAX_POS);
      send_fraction(-MAX_POS, -MAX_POS);
      send_fraction(1, 1);
      send_fraction(-1, -1);
      send_fraction(6, 4);
      send_fraction(-6, 4);
      send_fraction(6, -4);
      send_fraction(-6, -4);
      send_fraction(MAX_POS, 1);
      send_fraction(1, -MAX_POS);
      send_fraction(32'sh4000_0000, 32'sh0010_0000);
      send_fraction(-32'sh4000_0000, 32'sh6000_0000);
      send_fraction(MAX_POS, MAX_POS - 1);
      send_fraction(32'sh5555_5555, 32'shAAAA_AAAB);
   endtask

   initial begin
      word_type n, d;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = SEND_IDLE_PCT[ph];
         recv_stall_pct = RECV_STALL_PCT[ph];
         repeat (RAND_PER_PHASE) begin
            gen_fraction(n, d);
            send_fraction(n, d);
         end
         wait_drained();
      end
      repeat (300) @(posedge clock);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
